// ===== rtl/rnenc_pkg.sv =====
// ----------------------------------------------------------------------------
// rnenc_pkg
// Shared widths, symbol table and job type for the Roman numeral encoder.
// ----------------------------------------------------------------------------
package rnenc_pkg;

    localparam int NUM_W       = 12;
    localparam int SYM_W       = 8;
    localparam int POS_W       = 4;
    localparam int TABLE_LEN   = 13;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [NUM_W-1:0] NUM_LIMIT = 12'd3999;
    localparam logic [SYM_W-1:0] SYM_NONE  = 8'd0;

    typedef struct packed {
        logic             err;
        logic [NUM_W-1:0] number;
    } t_job;

    function automatic logic [NUM_W-1:0] sym_value(input logic [POS_W-1:0] pos);
        logic [NUM_W-1:0] v;
        case (pos)
            4'd0:    v = 12'd1000;
            4'd1:    v = 12'd900;
            4'd2:    v = 12'd500;
            4'd3:    v = 12'd400;
            4'd4:    v = 12'd100;
            4'd5:    v = 12'd90;
            4'd6:    v = 12'd50;
            4'd7:    v = 12'd40;
            4'd8:    v = 12'd10;
            4'd9:    v = 12'd9;
            4'd10:   v = 12'd5;
            4'd11:   v = 12'd4;
            default: v = 12'd1;
        endcase
        return v;
    endfunction

    function automatic logic [SYM_W-1:0] letter_a(input logic [POS_W-1:0] pos);
        logic [SYM_W-1:0] c;
        case (pos)
            4'd0:    c = "M";
            4'd1:    c = "C";
            4'd2:    c = "D";
            4'd3:    c = "C";
            4'd4:    c = "C";
            4'd5:    c = "X";
            4'd6:    c = "L";
            4'd7:    c = "X";
            4'd8:    c = "X";
            4'd9:    c = "I";
            4'd10:   c = "V";
            default: c = "I";
        endcase
        return c;
    endfunction

    function automatic logic [SYM_W-1:0] letter_b(input logic [POS_W-1:0] pos);
        logic [SYM_W-1:0] c;
        case (pos)
            4'd1:    c = "M";
            4'd3:    c = "D";
            4'd5:    c = "C";
            4'd7:    c = "L";
            4'd9:    c = "X";
            4'd11:   c = "V";
            default: c = SYM_NONE;
        endcase
        return c;
    endfunction

    // largest table value not above rem
    function automatic logic [POS_W-1:0] find_pos(input logic [NUM_W-1:0] rem);
        logic [POS_W-1:0] p;
        p = POS_W'(TABLE_LEN - 1);
        for (int i = TABLE_LEN - 1; i >= 0; i--) begin
            if (rem >= sym_value(POS_W'(i))) begin
                p = POS_W'(i);
            end
        end
        return p;
    endfunction

endpackage

// ===== rtl/rnenc_front.sv =====
// ----------------------------------------------------------------------------
// rnenc_front
// Accepts numbers, flags out-of-range values and queues them for the back end.
// ----------------------------------------------------------------------------
module rnenc_front #(
    parameter int DEPTH = rnenc_pkg::QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [rnenc_pkg::NUM_W-1:0] i_number,
    output logic                       o_full,
    output logic                       o_job_valid,
    output rnenc_pkg::t_job            o_job,
    input  logic                       i_take
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rnenc_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic            w_push;
    logic            w_pop;
    rnenc_pkg::t_job w_in;

    assign o_full      = (r_cnt == CW'(DEPTH));
    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_mem[r_rd];
    assign w_push      = i_push && !o_full;
    assign w_pop       = i_take && o_job_valid;

    always_comb begin
        w_in.number = i_number;
        w_in.err    = (i_number == '0) || (i_number > rnenc_pkg::NUM_LIMIT);
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/rnenc_back.sv =====
// ----------------------------------------------------------------------------
// rnenc_back
// Greedy-subtraction sequencer: a letter per cycle to a free output register.
// ----------------------------------------------------------------------------
module rnenc_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_job_valid,
    input  rnenc_pkg::t_job             i_job,
    output logic                        o_take,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic [rnenc_pkg::SYM_W-1:0] o_symbol,
    output logic                        o_last,
    output logic                        o_error
);

    logic                        r_busy, n_busy;
    logic                        r_err, n_err;
    logic                        r_pending, n_pending;
    logic [rnenc_pkg::NUM_W-1:0] r_rem, n_rem;
    logic [rnenc_pkg::POS_W-1:0] r_pos, n_pos;
    logic                        r_out_valid, n_out_valid;
    logic [rnenc_pkg::SYM_W-1:0] r_sym, n_sym;
    logic                        r_last, n_last;
    logic                        r_oerr, n_oerr;

    logic                        w_slot_free;
    logic [rnenc_pkg::POS_W-1:0] w_pos;
    logic [rnenc_pkg::POS_W-1:0] w_cur_pos;
    logic [rnenc_pkg::NUM_W-1:0] w_diff;

    assign w_slot_free = !r_out_valid || i_pop;
    assign w_pos       = rnenc_pkg::find_pos(r_rem);
    assign w_cur_pos   = r_pending ? r_pos : w_pos;
    assign w_diff      = r_rem - rnenc_pkg::sym_value(w_cur_pos);
    assign o_take      = !r_busy && i_job_valid;
    assign o_empty     = !r_out_valid;
    assign o_symbol    = r_sym;
    assign o_last      = r_last;
    assign o_error     = r_oerr;

    always_comb begin
        n_busy      = r_busy;
        n_err       = r_err;
        n_pending   = r_pending;
        n_rem       = r_rem;
        n_pos       = r_pos;
        n_out_valid = r_out_valid;
        n_sym       = r_sym;
        n_last      = r_last;
        n_oerr      = r_oerr;
        if (i_pop) begin
            n_out_valid = 1'b0;
        end
        if (o_take) begin
            n_busy    = 1'b1;
            n_err     = i_job.err;
            n_rem     = i_job.number;
            n_pending = 1'b0;
        end else if (r_busy && w_slot_free) begin
            n_out_valid = 1'b1;
            n_oerr      = 1'b0;
            if (r_err) begin
                n_sym  = rnenc_pkg::SYM_NONE;
                n_last = 1'b1;
                n_oerr = 1'b1;
                n_busy = 1'b0;
            end else if (r_pending) begin
                n_sym     = rnenc_pkg::letter_b(r_pos);
                n_rem     = w_diff;
                n_last    = (w_diff == '0);
                n_busy    = (w_diff != '0);
                n_pending = 1'b0;
            end else if (rnenc_pkg::letter_b(w_pos) != rnenc_pkg::SYM_NONE) begin
                n_sym     = rnenc_pkg::letter_a(w_pos);
                n_last    = 1'b0;
                n_pending = 1'b1;
                n_pos     = w_pos;
            end else begin
                n_sym  = rnenc_pkg::letter_a(w_pos);
                n_rem  = w_diff;
                n_last = (w_diff == '0);
                n_busy = (w_diff != '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_err  <= n_err;
        r_rem  <= n_rem;
        r_pos  <= n_pos;
        r_sym  <= n_sym;
        r_last <= n_last;
        r_oerr <= n_oerr;
    end

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_oerr |-> r_last && (r_sym == rnenc_pkg::SYM_NONE))
        else $error("error item without last or with a letter");

    a_pending_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |-> r_busy && !r_err)
        else $error("second letter pending while idle");

    a_rem_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !r_err |-> r_rem != '0)
        else $error("busy with nothing left to encode");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !$past(o_take) && $past(r_busy) && !r_pending |-> !o_take)
        else $error("job taken while encoding");

endmodule

// ===== rtl/integer_to_roman_numeral_encoder_top.sv =====
// ----------------------------------------------------------------------------
// integer_to_roman_numeral_encoder_top
// Converts 1..3999 to a Roman numeral, one ASCII letter per output item.
// ----------------------------------------------------------------------------
//  channel  handshake          payload
//  input    i_push / o_full    i_number[11:0]
//  output   o_empty / i_pop    o_symbol[7:0], o_last, o_error
//
//  Within a number, one output item per cycle while the output register is
//  free or popped; a number gives 1..15 letters after a load step in the
//  sequencer. Out-of-range input gives one error item.
//  A small queue decouples intake from the sequencer; i_pop low holds
//  the sequencer on its output register.
//  Synchronous active-low reset empties the queue and output register.
// ----------------------------------------------------------------------------
module integer_to_roman_numeral_encoder_top #(
    parameter int QUEUE_DEPTH = rnenc_pkg::QUEUE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic [rnenc_pkg::NUM_W-1:0] i_number,
    output logic                        o_full,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic [rnenc_pkg::SYM_W-1:0] o_symbol,
    output logic                        o_last,
    output logic                        o_error
);

    logic            w_job_valid;
    rnenc_pkg::t_job w_job;
    logic            w_take;

    rnenc_front #(
        .DEPTH(QUEUE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_number   (i_number),
        .o_full     (o_full),
        .o_job_valid(w_job_valid),
        .o_job      (w_job),
        .i_take     (w_take)
    );

    rnenc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(w_job_valid),
        .i_job      (w_job),
        .o_take     (w_take),
        .i_pop      (i_pop),
        .o_empty    (o_empty),
        .o_symbol   (o_symbol),
        .o_last     (o_last),
        .o_error    (o_error)
    );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the Roman numeral encoder against a cycle-free predictor.
// A clocked driver pushes numbers from a pending queue, and a clocked
// monitor predicts each numeral on acceptance and compares every popped
// letter with the oldest predicted one. Both sides idle at random in
// changing mixes. One long pop hold-off fills the block, and the sender
// drains completely between phases.
// ----------------------------------------------------------------------------
module tb;

    typedef struct packed {
        logic [rnenc_pkg::SYM_W-1:0] symbol;
        logic                        last;
        logic                        error;
    } t_roman_char;

    localparam string FIRST_LETTER  = "MCDCCXLXXIVII";
    localparam string SECOND_LETTER = " M D C L X V ";
    localparam int    HOLD_CYCLES   = 300;
    localparam int    DRAIN_CYCLES  = 40;
    localparam int    QUEUE_AHEAD   = 4;

    logic                        i_clk    = 1'b0;
    logic                        i_rst_n  = 1'b0;
    logic                        i_push   = 1'b0;
    logic [rnenc_pkg::NUM_W-1:0] i_number = '0;
    logic                        i_pop    = 1'b0;
    logic                        o_full;
    logic                        o_empty;
    logic [rnenc_pkg::SYM_W-1:0] o_symbol;
    logic                        o_last;
    logic                        o_error;

    logic [rnenc_pkg::NUM_W-1:0] number_q[$];
    t_roman_char                 numeral_q[$];
    t_roman_char                 want;
    int                          send_idle = 23;
    int                          recv_idle = 57;
    logic                        hold_req  = 1'b0;
    int                          hold_left = 0;
    int                          mismatches = 0;

    integer_to_roman_numeral_encoder_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .i_number (i_number),
        .o_full   (o_full),
        .i_pop    (i_pop),
        .o_empty  (o_empty),
        .o_symbol (o_symbol),
        .o_last   (o_last),
        .o_error  (o_error)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned rank_value(input int idx);
        case (idx)
            0:       return 1000;
            1:       return 900;
            2:       return 500;
            3:       return 400;
            4:       return 100;
            5:       return 90;
            6:       return 50;
            7:       return 40;
            8:       return 10;
            9:       return 9;
            10:      return 5;
            11:      return 4;
            default: return 1;
        endcase
    endfunction

    task automatic spell_numeral(input logic [rnenc_pkg::NUM_W-1:0] n);
        t_roman_char chars[$];
        t_roman_char c;
        int unsigned rem;
        int          pos;
        if (n == '0 || n > rnenc_pkg::NUM_LIMIT) begin
            c.symbol = rnenc_pkg::SYM_NONE;
            c.last   = 1'b1;
            c.error  = 1'b1;
            numeral_q.push_back(c);
        end else begin
            rem = n;
            pos = 0;
            c.last  = 1'b0;
            c.error = 1'b0;
            while (rem != 0) begin
                while (pos < 12 && rank_value(pos) > rem) pos++;
                c.symbol = FIRST_LETTER[pos];
                chars.push_back(c);
                if (SECOND_LETTER[pos] != " ") begin
                    c.symbol = SECOND_LETTER[pos];
                    chars.push_back(c);
                end
                rem -= rank_value(pos);
            end
            foreach (chars[i]) begin
                c      = chars[i];
                c.last = (i == chars.size() - 1);
                numeral_q.push_back(c);
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_push   <= 1'b0;
            i_number <= '0;
            i_pop    <= 1'b0;
        end else begin
            if (number_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                i_push   <= 1'b1;
                i_number <= number_q[0];
            end else begin
                i_push   <= 1'b0;
                i_number <= rnenc_pkg::NUM_W'($urandom);
            end
            i_pop <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_push && !o_full) begin
            spell_numeral(i_number);
            if (number_q.size() > 0) void'(number_q.pop_front());
        end
        if (i_rst_n && i_pop && !o_empty) begin
            if (numeral_q.size() == 0) begin
                report_mismatch($sformatf("unexpected item symbol=%02h last=%b error=%b",
                                          o_symbol, o_last, o_error));
            end else begin
                want = numeral_q.pop_front();
                if (o_symbol !== want.symbol)
                    report_mismatch($sformatf("symbol %02h, want %02h", o_symbol, want.symbol));
                if (o_last !== want.last)
                    report_mismatch($sformatf("last %b, want %b", o_last, want.last));
                if (o_error !== want.error)
                    report_mismatch($sformatf("error %b, want %b", o_error, want.error));
            end
        end
    end

    // hold pop low for a long stretch on request
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
        end
    end

    task automatic offer(input logic [rnenc_pkg::NUM_W-1:0] n);
        while (number_q.size() >= QUEUE_AHEAD) @(posedge i_clk);
        number_q.push_back(n);
    endtask

    task automatic drain_all;
        while (number_q.size() != 0 || numeral_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [rnenc_pkg::NUM_W-1:0] random_number();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 6)  return '0;
        if (pick < 14) return rnenc_pkg::NUM_W'($urandom_range(4095, 4000));
        if (pick < 30) return rnenc_pkg::NUM_W'($urandom_range(3999, 3000));
        return rnenc_pkg::NUM_W'($urandom_range(3999, 1));
    endfunction

    initial begin
        logic [rnenc_pkg::NUM_W-1:0] directed[$];
        directed = '{12'd1, 12'd3999, 12'd0, 12'd4000, 12'd4095, 12'd3888, 12'd4,
                     12'd9, 12'd40, 12'd90, 12'd400, 12'd900, 12'd5, 12'd50,
                     12'd500, 12'd1000, 12'd2048, 12'd1994, 12'd3, 12'd2,
                     12'd1111, 12'd3444, 12'd2999};
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed[i]) offer(directed[i]);
        drain_all();
        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 23 : (phase == 1) ? 57 : 0;
            recv_idle = (phase == 0) ? 57 : (phase == 1) ? 23 : 0;
            for (int k = 0; k < 32; k++) begin
                if (phase == 0 && k == 10) hold_req = 1'b1;
                offer(random_number());
            end
            drain_all();
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("integer_to_roman_numeral_encoder_top test passed");
        end else begin
            $display("integer_to_roman_numeral_encoder_top test failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("%0t ns: timeout", $time);
        $display("integer_to_roman_numeral_encoder_top test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rnenc_pkg.sv
rtl/rnenc_front.sv
rtl/rnenc_back.sv
rtl/integer_to_roman_numeral_encoder_top.sv
dv/tb.sv
